>>> sv/gals_pkg.sv
// Package for the graph adjacency list store: sizes, command, status and register
// codes, and the command record passed from the front end to the back end. No dependencies.
package gals_pkg;

  localparam int unsigned MaxNodes  = 256;
  localparam int unsigned MaxDegree = 16;
  localparam int unsigned NodeW     = 8;
  localparam int unsigned SlotW     = 4;   // log2(MaxDegree)
  localparam int unsigned CntW      = 5;   // holds 0..MaxDegree
  localparam int unsigned AddrW     = NodeW + SlotW;
  localparam int unsigned MemDepth  = MaxNodes * MaxDegree;
  localparam int unsigned WeightW   = 32;
  localparam int unsigned QDepth    = 2;

  localparam logic [2:0] CmdAdd1 = 3'd0;
  localparam logic [2:0] CmdAdd2 = 3'd1;
  localparam logic [2:0] CmdRem1 = 3'd2;
  localparam logic [2:0] CmdRem2 = 3'd3;
  localparam logic [2:0] CmdQry  = 3'd4;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StPresent  = 3'd1;
  localparam logic [2:0] StSelf     = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;
  localparam logic [2:0] StInMiss   = 3'd5;

  localparam logic [1:0] CfgSelfLoops = 2'd0;
  localparam logic [1:0] CfgWeighted  = 2'd1;
  localparam logic [1:0] CfgDirected  = 2'd2;

  typedef enum logic [1:0] {
    OpAdd   = 2'd0,
    OpRem   = 2'd1,
    OpQuery = 2'd2
  } op_e;

  // One direction of work for the back end.
  typedef struct packed {
    op_e                op;
    logic [NodeW-1:0]   src;
    logic [NodeW-1:0]   dst;
    logic [WeightW-1:0] weight;
    logic               last;
  } job_t;

endpackage

>>> sv/gals_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module gals_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> sv/gals_front.sv
// Front end: accepts commands, splits two-way commands into two directions,
// drops unused codes and queues the jobs. Depends on gals_pkg.
module gals_front
  import gals_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       cmd_i,
  input  logic [NodeW-1:0] src_i,
  input  logic [NodeW-1:0] dst_i,
  input  logic [31:0]      weight_i,
  output logic             job_valid_o,
  input  logic             job_ready_i,
  output job_t             job_o
);

  job_t       q_mem_q [QDepth];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, wr_q;
  logic       two_way;
  job_t       j0, j1;
  logic       push0, push1, pop;

  always_comb begin
    j0 = '{op: OpQuery, src: src_i, dst: dst_i, weight: weight_i, last: 1'b1};
    j1 = '{op: OpQuery, src: dst_i, dst: src_i, weight: weight_i, last: 1'b1};
    two_way = 1'b0;
    case (cmd_i)
      CmdAdd1: j0.op = OpAdd;
      CmdAdd2: begin j0.op = OpAdd; j1.op = OpAdd; two_way = 1'b1; end
      CmdRem1: j0.op = OpRem;
      CmdRem2: begin j0.op = OpRem; j1.op = OpRem; two_way = 1'b1; end
      default: ;
    endcase
    if (two_way) j0.last = 1'b0;
  end

  // Accept only when both directions fit at once.
  assign in_ready_o  = (cnt_q == 2'd0);
  assign push0       = in_valid_i && in_ready_o && (cmd_i <= CmdQry);
  assign push1       = push0 && two_way;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = q_mem_q[rd_q];
  assign pop         = job_valid_o && job_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push0) cnt_d = push1 ? 2'd2 : 2'd1;
    else if (pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (pop) rd_q <= ~rd_q;
      if (push0) wr_q <= push1 ? wr_q : ~wr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0) begin
      q_mem_q[wr_q] <= j0;
      if (push1) q_mem_q[~wr_q] <= j1;
    end
  end

endmodule

>>> sv/gals_back.sv
// Back end: sequencer that scans, appends and shifts the list memories and
// forms one result per job. Depends on gals_pkg and gals_ram.
module gals_back
  import gals_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               self_loops_i,
  input  logic               weighted_i,
  input  logic               directed_i,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  job_t               job_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [2:0]         status_o,
  output logic               found_o,
  output logic [WeightW-1:0] fweight_o,
  output logic               last_o
);

  typedef enum logic [3:0] {
    SClear, SIdle, SDegChk, SOutRd, SOutChk, SInRd, SInChk, SDecide,
    SOutShRd, SOutShWr, SInShRd, SInShWr, SResult
  } state_e;

  state_e             state_q;
  job_t               job_q;
  logic [NodeW-1:0]   clr_q;
  logic [CntW-1:0]    n_q, k_q, idx_q, po_q, pi_q;
  logic [2:0]         st_q;
  logic               found_q;
  logic [WeightW-1:0] fw_q;

  logic               on_we, ow_we, in_we, od_we, id_we;
  logic [AddrW-1:0]   o_addr, i_addr;
  logic [NodeW-1:0]   on_wd, on_rd, in_wd, in_rd, od_addr, id_addr;
  logic [WeightW-1:0] ow_wd, ow_rd;
  logic [CntW-1:0]    od_wd, od_rd, id_wd, id_rd;

  gals_ram #(.Width(NodeW), .Depth(MemDepth)) u_out_nb (
    .clk_i, .we_i(on_we), .addr_i(o_addr), .wdata_i(on_wd), .rdata_o(on_rd));
  gals_ram #(.Width(WeightW), .Depth(MemDepth)) u_out_w (
    .clk_i, .we_i(ow_we), .addr_i(o_addr), .wdata_i(ow_wd), .rdata_o(ow_rd));
  gals_ram #(.Width(NodeW), .Depth(MemDepth)) u_in_nb (
    .clk_i, .we_i(in_we), .addr_i(i_addr), .wdata_i(in_wd), .rdata_o(in_rd));
  gals_ram #(.Width(CntW), .Depth(MaxNodes)) u_out_deg (
    .clk_i, .we_i(od_we), .addr_i(od_addr), .wdata_i(od_wd), .rdata_o(od_rd));
  gals_ram #(.Width(CntW), .Depth(MaxNodes)) u_in_deg (
    .clk_i, .we_i(id_we), .addr_i(id_addr), .wdata_i(id_wd), .rdata_o(id_rd));

  logic            is_self, self_ok, room_full;
  logic [CntW-1:0] idx_nx;

  assign idx_nx    = idx_q + CntW'(1);
  assign is_self   = (job_q.src == job_q.dst);
  assign self_ok   = self_loops_i && weighted_i;
  assign room_full = (n_q >= CntW'(MaxDegree)) || (k_q >= CntW'(MaxDegree));

  assign job_ready_o = (state_q == SIdle);
  assign res_valid_o = (state_q == SResult);
  assign status_o    = st_q;
  assign found_o     = found_q;
  assign fweight_o   = fw_q;
  assign last_o      = job_q.last;

  // Memory port control. Degree counts are read while the job is taken.
  always_comb begin
    od_addr = (state_q == SIdle) ? job_i.src : job_q.src;
    id_addr = (state_q == SIdle) ? job_i.dst : job_q.dst;
    od_we   = 1'b0;
    id_we   = 1'b0;
    od_wd   = n_q + CntW'(1);
    id_wd   = k_q + CntW'(1);
    on_we   = 1'b0;
    ow_we   = 1'b0;
    in_we   = 1'b0;
    o_addr  = {job_q.src, idx_q[SlotW-1:0]};
    i_addr  = {job_q.dst, idx_q[SlotW-1:0]};
    on_wd   = on_rd;
    ow_wd   = ow_rd;
    in_wd   = in_rd;
    case (state_q)
      SClear: begin
        od_addr = clr_q;
        id_addr = clr_q;
        od_we   = 1'b1;
        id_we   = 1'b1;
        od_wd   = '0;
        id_wd   = '0;
      end
      SDecide: begin
        if (job_q.op == OpAdd) begin
          o_addr = {job_q.src, n_q[SlotW-1:0]};
          i_addr = {job_q.dst, k_q[SlotW-1:0]};
          on_wd  = job_q.dst;
          ow_wd  = weighted_i ? job_q.weight : '0;
          in_wd  = job_q.src;
          if (!room_full) begin
            on_we = 1'b1;
            ow_we = 1'b1;
            in_we = directed_i;
            od_we = 1'b1;
            id_we = 1'b1;
          end
        end else begin
          // Drop both counts; the in count stops at zero.
          od_we = 1'b1;
          od_wd = n_q - CntW'(1);
          id_we = (k_q != '0);
          id_wd = k_q - CntW'(1);
        end
      end
      SOutShWr: begin
        o_addr = {job_q.src, idx_q[SlotW-1:0] - SlotW'(1)};
        on_we  = 1'b1;
        ow_we  = 1'b1;
      end
      SInShWr: begin
        i_addr = {job_q.dst, idx_q[SlotW-1:0] - SlotW'(1)};
        in_we  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      clr_q   <= '0;
      job_q   <= '0;
      n_q     <= '0;
      k_q     <= '0;
      idx_q   <= '0;
      po_q    <= '0;
      pi_q    <= '0;
      st_q    <= StOk;
      found_q <= 1'b0;
      fw_q    <= '0;
    end else begin
      case (state_q)
        SClear: begin
          clr_q <= clr_q + NodeW'(1);
          if (clr_q == '1) state_q <= SIdle;
        end
        SIdle: if (job_valid_i) begin
          job_q   <= job_i;
          found_q <= 1'b0;
          fw_q    <= '0;
          st_q    <= StOk;
          state_q <= SDegChk;
        end
        SDegChk: begin
          n_q   <= od_rd;
          k_q   <= id_rd;
          idx_q <= '0;
          if (job_q.op == OpAdd && is_self && !self_ok) begin
            st_q <= StSelf; state_q <= SResult;
          end else if (job_q.op == OpRem && is_self) begin
            st_q <= StSelf; state_q <= SResult;
          end else if (od_rd == '0) begin
            if (job_q.op == OpAdd) begin
              state_q <= SDecide;
            end else begin
              if (job_q.op == OpRem) st_q <= StNotFound;
              state_q <= SResult;
            end
          end else begin
            state_q <= SOutRd;
          end
        end
        SOutRd: state_q <= SOutChk;
        SOutChk: begin
          if (on_rd == job_q.dst) begin
            case (job_q.op)
              OpQuery: begin
                found_q <= 1'b1; fw_q <= ow_rd; state_q <= SResult;
              end
              OpAdd: begin
                st_q <= StPresent; state_q <= SResult;
              end
              default: begin
                po_q <= idx_q;
                if (!directed_i) begin
                  state_q <= SDecide;
                end else if (k_q == '0) begin
                  st_q <= StInMiss; state_q <= SResult;
                end else begin
                  idx_q <= '0; state_q <= SInRd;
                end
              end
            endcase
          end else if (idx_nx >= n_q) begin
            case (job_q.op)
              OpAdd: state_q <= SDecide;
              OpRem: begin
                st_q <= StNotFound; state_q <= SResult;
              end
              default: state_q <= SResult;
            endcase
          end else begin
            idx_q   <= idx_nx;
            state_q <= SOutRd;
          end
        end
        SInRd: state_q <= SInChk;
        SInChk: begin
          if (in_rd == job_q.src) begin
            pi_q    <= idx_q;
            state_q <= SDecide;
          end else if (idx_nx >= k_q) begin
            st_q <= StInMiss; state_q <= SResult;
          end else begin
            idx_q   <= idx_nx;
            state_q <= SInRd;
          end
        end
        SDecide: begin
          if (job_q.op == OpAdd) begin
            if (room_full) st_q <= StFull;
            state_q <= SResult;
          end else begin
            idx_q   <= po_q + CntW'(1);
            state_q <= SOutShRd;
          end
        end
        SOutShRd: begin
          if (idx_q >= n_q) begin
            idx_q   <= pi_q + CntW'(1);
            state_q <= directed_i ? SInShRd : SResult;
          end else begin
            state_q <= SOutShWr;
          end
        end
        SOutShWr: begin
          // Entry read at idx_q is on the read port now; write it one slot down.
          idx_q   <= idx_nx;
          state_q <= SOutShRd;
        end
        SInShRd: begin
          if (idx_q >= k_q) state_q <= SResult;
          else state_q <= SInShWr;
        end
        SInShWr: begin
          idx_q   <= idx_nx;
          state_q <= SInShRd;
        end
        SResult: if (res_ready_i) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule

>>> sv/graph_adjacency_list_store.sv
// Top level of the graph adjacency list store: configuration registers and
// the front/back split. Depends on gals_pkg, gals_front, gals_back, gals_ram.
//
// Keeps up to 256 nodes, each with an out list of up to 16 links (8-bit
// neighbour and 32-bit weight) and, in directed mode, an in list. A command
// is accepted on s_axis when the front queue is empty; two-way commands yield
// two results, the second with tlast set, and unused codes yield none. The
// back end visits the list slots one at a time through single-port RAMs
// with registered reads; a two-way command runs through it twice, and each
// result is held until m_axis_tready. After reset the degree counts of all
// 256 nodes are cleared before the first command starts. Configuration
// writes are taken at any time; change modes only while no command is in
// flight.
module graph_adjacency_list_store
  import gals_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic        cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd[2:0], source_node[10:3], target_node[18:11], link_weight[50:19], pad
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], link_found[3], found_weight[35:4], pad
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  logic  self_q, weighted_q, directed_q;
  logic  job_valid, job_ready;
  job_t  job;
  logic [2:0]         status;
  logic               found;
  logic [WeightW-1:0] fweight;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_q <= 1'b0; weighted_q <= 1'b0; directed_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgSelfLoops: self_q <= cfg_data_i;
        CfgWeighted:  weighted_q <= cfg_data_i;
        CfgDirected:  directed_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gals_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .cmd_i(s_axis_tdata[2:0]), .src_i(s_axis_tdata[10:3]),
    .dst_i(s_axis_tdata[18:11]), .weight_i(s_axis_tdata[50:19]),
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job));

  gals_back u_back (
    .clk_i, .rst_ni,
    .self_loops_i(self_q), .weighted_i(weighted_q), .directed_i(directed_q),
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .status_o(status), .found_o(found), .fweight_o(fweight),
    .last_o(m_axis_tlast));

  assign m_axis_tdata = {4'b0, fweight, found, status};

endmodule
